>>> rtl/eusa_pkg.sv
// Shared constants, types and register codes for the encoder unwrap and speed average block.
// Depends on nothing; every other file but eusa_ram refers to it by scoped names.

package eusa_pkg;

    // Encoder geometry and averaging window.
    localparam int COUNTS_PER_TURN = 8192;
    localparam int AVG_DEPTH       = 16;

    // Field widths of the sample and result items.
    localparam int RAW_W   = 13;
    localparam int POS_W   = 38;
    localparam int TURN_W  = 24;
    localparam int DELTA_W = 14;
    localparam int AVG_W   = 22;

    // Configuration register widths and reset values.
    localparam int INIT_W = 8;
    localparam int THR_W  = 13;
    localparam logic [INIT_W-1:0] INIT_FRAMES_RESET    = 8'd10;
    localparam logic [THR_W-1:0]  JUMP_THRESHOLD_RESET = 13'd4096;

    // Configuration port geometry: registers at byte addresses 0 and 4.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_INIT_FRAMES    = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_JUMP_THRESHOLD = 1'b1;

    // Derived widths of the averaging datapath.
    localparam int IDX_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int FILL_W  = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W   = DELTA_W + FILL_W;
    localparam int Q_SHIFT = 8;
    localparam int NUM_W   = SUM_W + Q_SHIFT;
    localparam int CNT_W   = $clog2(NUM_W);
    localparam int CPT_W   = $clog2(COUNTS_PER_TURN + 1);

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Request and response of the iterative divider.
    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] dividend;
        logic [FILL_W-1:0]       divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/eusa_sample_if.sv
// Valid/ready channel that carries one raw encoder sample item.
// Depends on eusa_pkg for the field width.

interface eusa_sample_if;
    logic                        valid;
    logic                        ready;
    logic [eusa_pkg::RAW_W-1:0]  raw_count;

    modport source (output valid, output raw_count, input ready);
    modport sink   (input valid, input raw_count, output ready);
endinterface

>>> rtl/eusa_result_if.sv
// Valid/ready channel that carries one position and speed result item.
// Depends on eusa_pkg for the field widths.

interface eusa_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [eusa_pkg::POS_W-1:0]   position;
    logic signed [eusa_pkg::TURN_W-1:0]  turn_count;
    logic signed [eusa_pkg::DELTA_W-1:0] delta;
    logic signed [eusa_pkg::AVG_W-1:0]   avg_rate;
    logic                                ready_res;

    modport source (output valid, output position, output turn_count, output delta,
                    output avg_rate, output ready_res, input ready);
    modport sink   (input valid, input position, input turn_count, input delta,
                    input avg_rate, input ready_res, output ready);
endinterface

>>> rtl/eusa_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; used for the delta history ring.

module eusa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, enabled by re.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/eusa_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend and unsigned divisor.
// Depends on eusa_pkg for widths and the request and response structs.

module eusa_div (
    input  logic               clk,
    input  logic               rst_n,
    input  eusa_pkg::div_req_t req,
    output eusa_pkg::div_rsp_t rsp
);

    localparam int NW = eusa_pkg::NUM_W;
    localparam int DW = eusa_pkg::FILL_W;

    logic            busy_reg;
    logic            done_reg;
    logic [eusa_pkg::CNT_W-1:0] cnt_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   dsr_reg;
    logic [NW-1:0]   quo_reg;
    logic            neg_reg;

    logic [NW-1:0]   mag;
    logic [DW:0]     shifted;
    logic            fits;
    logic [DW:0]     rem_step;

    // Magnitude of the dividend; the sign is reapplied at the end.
    assign mag = req.dividend[NW-1] ? (~req.dividend + 1'b1) : req.dividend;

    // One restoring step: shift in the next dividend bit and try a subtraction.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NW-1]};
        fits     = (shifted >= {1'b0, dsr_reg});
        rem_step = fits ? (shifted - {1'b0, dsr_reg}) : shifted;
    end

    // Control: busy while bits remain, done pulses after the last step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= eusa_pkg::CNT_W'(NW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient register starts out holding the dividend magnitude.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= mag;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
            neg_reg <= req.dividend[NW-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], fits};
            rem_reg <= rem_step[DW-1:0];
        end
    end

    // Truncation toward zero: negate the magnitude quotient for a negative dividend.
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? $signed(~quo_reg + 1'b1) : $signed(quo_reg);

endmodule

>>> rtl/encoder_unwrap_speed_average.sv
// Top level of the encoder unwrap and speed average block.
// Depends on eusa_pkg, eusa_sample_if, eusa_result_if, eusa_ram and eusa_div.
//
// Usage: each sample item carries one 13-bit single-turn encoder count. For
// every sample the block returns one result item with the multi-turn position,
// the turn counter, the unwrapped delta, the Q8 moving average of the last
// sixteen deltas and a flag that bias capture is complete.
// Timing: a sample is taken in the idle state only. The delta history ring is
// read in the accept cycle, updated in the next one, and the average is then
// formed by a restoring divider at one quotient bit per cycle (27 bits). No new
// sample is taken until the result of the last one is in the output register.
// The result sits in an output register; a stalled receiver holds it there,
// and the block stops in its last step until the register is free.
// Reset clears the turn counter, bias, history pointers and running sum and
// restores init_frames to 10 and jump_threshold to 4096. History entries are
// only read once written, so the ring needs no clearing pass.
// Configuration: APB registers init_frames at 0x0 and jump_threshold at 0x4.

module encoder_unwrap_speed_average (
    input  logic                              clk,
    input  logic                              rst_n,
    eusa_sample_if.sink                       sample,
    eusa_result_if.source                     result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [eusa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [eusa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [eusa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int DW   = eusa_pkg::DELTA_W;
    localparam int SW   = eusa_pkg::SUM_W;
    localparam int PW   = eusa_pkg::TURN_W + eusa_pkg::CPT_W + 1;
    localparam int EW   = (PW > eusa_pkg::POS_W) ? PW : eusa_pkg::POS_W;

    // Configuration registers.
    logic [eusa_pkg::INIT_W-1:0]   init_frames_reg;
    logic [eusa_pkg::THR_W-1:0]    jump_threshold_reg;
    logic [eusa_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cfg_write;

    // Sequencer and scalar state.
    eusa_pkg::state_t              state_reg;
    eusa_pkg::state_t              state_next;
    logic [eusa_pkg::RAW_W-1:0]    last_raw_reg;
    logic [eusa_pkg::RAW_W-1:0]    bias_reg;
    logic signed [eusa_pkg::TURN_W-1:0] turns_reg;
    logic [eusa_pkg::INIT_W-1:0]   init_count_reg;
    logic [eusa_pkg::FILL_W-1:0]   fill_count_reg;
    logic [eusa_pkg::IDX_W-1:0]    write_index_reg;
    logic signed [SW-1:0]          delta_sum_reg;

    // Per-item working registers.
    logic [eusa_pkg::RAW_W-1:0]    raw_reg;
    logic signed [DW-1:0]          delta_reg;
    logic                          ready_flag_reg;
    logic signed [eusa_pkg::POS_W-1:0] position_reg;

    // Output register.
    logic                          res_valid_reg;
    logic signed [eusa_pkg::POS_W-1:0]  res_position_reg;
    logic signed [eusa_pkg::TURN_W-1:0] res_turns_reg;
    logic signed [DW-1:0]          res_delta_reg;
    logic signed [eusa_pkg::AVG_W-1:0]  res_avg_reg;
    logic                          res_ready_reg;

    // Sequencer outputs.
    logic                          accept;
    logic                          ram_re;
    logic                          ram_we;
    logic                          emit_load;
    logic                          div_start;

    // Accept-cycle datapath.
    logic                          capture;
    logic [eusa_pkg::RAW_W-1:0]    bias_next;
    logic [eusa_pkg::INIT_W-1:0]   init_count_next;
    logic signed [DW-1:0]          d_raw;
    logic signed [DW-1:0]          thr;
    logic signed [DW-1:0]          delta_next;
    logic signed [eusa_pkg::TURN_W-1:0] turns_next;

    // Update-cycle datapath.
    logic [DW-1:0]                 ram_rdata;
    logic                          window_full;
    logic signed [SW-1:0]          delta_sum_next;
    logic [eusa_pkg::FILL_W-1:0]   fill_count_next;
    logic [eusa_pkg::IDX_W-1:0]    write_index_next;
    logic signed [PW-1:0]          turn_prod;
    logic signed [EW-1:0]          pos_wide;
    logic signed [DW-1:0]          offset;
    eusa_pkg::div_req_t            div_req;
    eusa_pkg::div_rsp_t            div_rsp;

    // Configuration port: writes land in the access phase, reads are direct.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[eusa_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_frames_reg    <= eusa_pkg::INIT_FRAMES_RESET;
            jump_threshold_reg <= eusa_pkg::JUMP_THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                eusa_pkg::REG_INIT_FRAMES:
                    init_frames_reg <= pwdata[eusa_pkg::INIT_W-1:0];
                eusa_pkg::REG_JUMP_THRESHOLD:
                    jump_threshold_reg <= pwdata[eusa_pkg::THR_W-1:0];
                default:
                    init_frames_reg <= init_frames_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            eusa_pkg::REG_INIT_FRAMES:
                prdata = eusa_pkg::APB_DATA_W'(init_frames_reg);
            eusa_pkg::REG_JUMP_THRESHOLD:
                prdata = eusa_pkg::APB_DATA_W'(jump_threshold_reg);
            default:
                prdata = '0;
        endcase
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            eusa_pkg::ST_IDLE:
                if (sample.valid)
                begin
                    state_next = eusa_pkg::ST_READ;
                end
            eusa_pkg::ST_READ:
                state_next = eusa_pkg::ST_DIV;
            eusa_pkg::ST_DIV:
                if (div_rsp.done)
                begin
                    state_next = eusa_pkg::ST_EMIT;
                end
            eusa_pkg::ST_EMIT:
                if (!res_valid_reg || result.ready)
                begin
                    state_next = eusa_pkg::ST_IDLE;
                end
            default:
                state_next = eusa_pkg::ST_IDLE;
        endcase
    end

    // Output logic of the sequencer.
    always_comb
    begin
        sample.ready = 1'b0;
        ram_we       = 1'b0;
        div_start    = 1'b0;
        emit_load    = 1'b0;
        case (state_reg)
            eusa_pkg::ST_IDLE:
                sample.ready = 1'b1;
            eusa_pkg::ST_READ:
            begin
                ram_we    = 1'b1;
                div_start = 1'b1;
            end
            eusa_pkg::ST_DIV:
                emit_load = 1'b0;
            eusa_pkg::ST_EMIT:
                emit_load = !res_valid_reg || result.ready;
            default:
                sample.ready = 1'b0;
        endcase
    end

    assign accept = sample.valid && sample.ready;
    assign ram_re = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eusa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Bias capture and turn unwrap, evaluated as the sample is taken.
    always_comb
    begin
        capture         = (init_count_reg < init_frames_reg);
        bias_next       = capture ? sample.raw_count : bias_reg;
        init_count_next = capture ? (init_count_reg + 1'b1) : init_count_reg;
        d_raw           = $signed({1'b0, sample.raw_count}) - $signed({1'b0, last_raw_reg});
        thr             = $signed({1'b0, jump_threshold_reg});
        delta_next      = d_raw;
        turns_next      = turns_reg;
        if (d_raw > thr)
        begin
            delta_next = d_raw - $signed(DW'(eusa_pkg::COUNTS_PER_TURN));
            turns_next = turns_reg - 1'b1;
        end
        else if (d_raw < -thr)
        begin
            delta_next = d_raw + $signed(DW'(eusa_pkg::COUNTS_PER_TURN));
            turns_next = turns_reg + 1'b1;
        end
    end

    // Delta history ring; the entry at the write pointer is the one that leaves the window.
    eusa_ram #(
        .WIDTH (DW),
        .DEPTH (eusa_pkg::AVG_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (write_index_reg),
        .wdata (delta_reg),
        .re    (ram_re),
        .raddr (write_index_reg),
        .rdata (ram_rdata)
    );

    // Running sum, fill count and pointer update in the cycle after the ring read.
    always_comb
    begin
        window_full      = (fill_count_reg >= eusa_pkg::FILL_W'(eusa_pkg::AVG_DEPTH));
        delta_sum_next   = delta_sum_reg + SW'(delta_reg);
        fill_count_next  = fill_count_reg;
        if (window_full)
        begin
            delta_sum_next = delta_sum_reg + SW'(delta_reg) - SW'($signed(ram_rdata));
        end
        else
        begin
            fill_count_next = fill_count_reg + 1'b1;
        end
        if (write_index_reg == eusa_pkg::IDX_W'(eusa_pkg::AVG_DEPTH - 1))
        begin
            write_index_next = '0;
        end
        else
        begin
            write_index_next = write_index_reg + 1'b1;
        end
    end

    // Multi-turn position: offset from the bias plus whole turns.
    assign offset    = $signed({1'b0, raw_reg}) - $signed({1'b0, bias_reg});
    assign turn_prod = turns_reg * $signed({1'b0, eusa_pkg::CPT_W'(eusa_pkg::COUNTS_PER_TURN)});
    assign pos_wide  = EW'(turn_prod) + EW'(offset);

    // The mean in Q8 is the scaled sum over the fill count.
    assign div_req = {div_start, delta_sum_next, {eusa_pkg::Q_SHIFT{1'b0}}, fill_count_next};

    eusa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Scalar state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg    <= '0;
            bias_reg        <= '0;
            turns_reg       <= '0;
            init_count_reg  <= '0;
            fill_count_reg  <= '0;
            write_index_reg <= '0;
            delta_sum_reg   <= '0;
        end
        else if (accept)
        begin
            last_raw_reg   <= sample.raw_count;
            bias_reg       <= bias_next;
            turns_reg      <= turns_next;
            init_count_reg <= init_count_next;
        end
        else if (ram_we)
        begin
            fill_count_reg  <= fill_count_next;
            write_index_reg <= write_index_next;
            delta_sum_reg   <= delta_sum_next;
        end
    end

    // Per-item working registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg        <= sample.raw_count;
            delta_reg      <= delta_next;
            ready_flag_reg <= (init_count_next >= init_frames_reg);
        end
        if (ram_we)
        begin
            position_reg <= pos_wide[eusa_pkg::POS_W-1:0];
        end
    end

    // Output register: loaded in the last step, cleared when the item is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            res_position_reg <= position_reg;
            res_turns_reg    <= turns_reg;
            res_delta_reg    <= delta_reg;
            res_avg_reg      <= div_rsp.quotient[eusa_pkg::AVG_W-1:0];
            res_ready_reg    <= ready_flag_reg;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.position   = res_position_reg;
    assign result.turn_count = res_turns_reg;
    assign result.delta      = res_delta_reg;
    assign result.avg_rate   = res_avg_reg;
    assign result.ready_res  = res_ready_reg;

    // One item at a time: taking a sample closes the input until the item is done.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !sample.ready)
    else $error("sample taken while an item was still in progress");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == eusa_pkg::ST_DIV))
    else $error("divider finished outside the wait step");

    // The fill count never passes the window depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= eusa_pkg::FILL_W'(eusa_pkg::AVG_DEPTH))
    else $error("fill count beyond the window depth");

    // A result is loaded only once the output register is free or being emptied.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |-> (!res_valid_reg || result.ready))
    else $error("result overwritten before it was taken");

endmodule
